FILE: design/crru_pkg.sv
// Shared definitions for the CRI/SSBRI + RSRP report unpacker.
// Holds sizes, RSRP constants, the decoded report type and field helpers.
// No dependencies.
package crru_pkg;

	localparam int MAX_REPORTED    = 4;
	localparam int MAX_REPORT_BITS = 43;
	localparam int WORD_BITS       = 64;

	localparam int CRI_W   = 6;
	localparam int RSRP_W  = 9;
	localparam int REF_W   = 7;
	localparam int DIFF_W  = 4;
	localparam int IDX_W   = 2;
	localparam int LEN_W   = 6;
	localparam int RCNT_W  = 7;
	localparam int NREP_W  = 3;
	localparam int CFGI_W  = 2;
	localparam int POS_W   = 6;

	localparam logic [CFGI_W-1:0] CFG_RESOURCE_COUNT = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_REPORTED_COUNT = 2'd1;

	localparam logic [RCNT_W-1:0] RESOURCE_COUNT_MAX = 7'd64;
	localparam logic signed [RSRP_W-1:0] RSRP_BASE_DBM = -9'sd140;

	// One decoded report: every entry is filled, last_idx says how many count.
	typedef struct packed {
		logic [MAX_REPORTED-1:0][CRI_W-1:0]  cri;
		logic [MAX_REPORTED-1:0][RSRP_W-1:0] rsrp;
		logic [IDX_W-1:0]                    last_idx;
		logic                                mismatch;
	} report_set_t;

	// Width of one CRI field: ceil(log2(count)) with count clamped to 1..64.
	function automatic logic [2:0] cri_width(input logic [RCNT_W-1:0] count);
		logic [RCNT_W-1:0] c;
		logic [2:0] w;
		c = count;
		if (c == '0) begin
			c = 7'd1;
		end
		if (c > RESOURCE_COUNT_MAX) begin
			c = RESOURCE_COUNT_MAX;
		end
		c = c - 7'd1;
		if (c[5]) w = 3'd6;
		else if (c[4]) w = 3'd5;
		else if (c[3]) w = 3'd4;
		else if (c[2]) w = 3'd3;
		else if (c[1]) w = 3'd2;
		else if (c[0]) w = 3'd1;
		else w = 3'd0;
		return w;
	endfunction

	// Reads a field MSB first: the bit at pos becomes the field's top bit.
	function automatic logic [REF_W-1:0] take_field(input logic [WORD_BITS-1:0] word,
			input logic [POS_W-1:0] pos, input logic [2:0] width);
		logic [REF_W-1:0] v;
		logic [POS_W-1:0] p;
		v = '0;
		for (int k = 0; k < REF_W; k++) begin
			if (3'(k) < width) begin
				p = pos + POS_W'(k);
				v = {v[REF_W-2:0], word[p]};
			end
		end
		return v;
	endfunction

endpackage

FILE: design/crru_decode.sv
// Field decoder of the report unpacker: one registered report in, all entries out.
// Pure combinational logic; depends on crru_pkg.
module crru_decode (
	input  logic [crru_pkg::MAX_REPORT_BITS-1:0] report_bits,
	input  logic [crru_pkg::LEN_W-1:0]           report_length,
	input  logic [crru_pkg::RCNT_W-1:0]          resource_count,
	input  logic [crru_pkg::NREP_W-1:0]          reported_count,
	output crru_pkg::report_set_t                set
);

	logic [crru_pkg::WORD_BITS-1:0] word;
	logic [2:0] cw;
	logic [crru_pkg::IDX_W-1:0] nm1;
	logic [crru_pkg::NREP_W-1:0] n;
	logic [crru_pkg::POS_W-1:0] ref_off;
	logic [crru_pkg::POS_W-1:0] diff_base;
	logic [crru_pkg::POS_W-1:0] expected;
	logic [crru_pkg::REF_W-1:0] ref_raw;
	logic signed [crru_pkg::RSRP_W-1:0] ref_dbm;

	// Positions past the end of the report read as zero.
	assign word = {{(crru_pkg::WORD_BITS - crru_pkg::MAX_REPORT_BITS){1'b0}}, report_bits};
	assign cw   = crru_pkg::cri_width(resource_count);

	always_comb begin
		if (reported_count == '0) begin
			nm1 = '0;
		end else if (reported_count > crru_pkg::NREP_W'(crru_pkg::MAX_REPORTED)) begin
			nm1 = crru_pkg::IDX_W'(crru_pkg::MAX_REPORTED - 1);
		end else begin
			nm1 = crru_pkg::IDX_W'(reported_count - 3'd1);
		end
	end

	assign n         = {1'b0, nm1} + 3'd1;
	assign ref_off   = crru_pkg::POS_W'({3'b000, n} * {3'b000, cw});
	assign diff_base = ref_off + crru_pkg::POS_W'(crru_pkg::REF_W);
	assign expected  = diff_base + {2'b00, nm1, 2'b00};
	assign ref_raw   = crru_pkg::take_field(word, ref_off, 3'(crru_pkg::REF_W));
	assign ref_dbm   = $signed({2'b00, ref_raw}) + crru_pkg::RSRP_BASE_DBM;

	always_comb begin
		logic [crru_pkg::POS_W-1:0] cri_off;
		logic [crru_pkg::POS_W-1:0] diff_off;
		logic [crru_pkg::REF_W-1:0] f;
		set.last_idx = nm1;
		set.mismatch = (report_length != expected);
		for (int i = 0; i < crru_pkg::MAX_REPORTED; i++) begin
			cri_off = crru_pkg::POS_W'(i) * {3'b000, cw};
			f = crru_pkg::take_field(word, cri_off, cw);
			set.cri[i] = f[crru_pkg::CRI_W-1:0];
			if (i == 0) begin
				set.rsrp[i] = ref_dbm;
			end else begin
				diff_off = diff_base + crru_pkg::POS_W'(crru_pkg::DIFF_W * (i - 1));
				f = crru_pkg::take_field(word, diff_off, 3'(crru_pkg::DIFF_W));
				set.rsrp[i] = ref_dbm - $signed({4'b0000, f[crru_pkg::DIFF_W-1:0], 1'b0});
			end
		end
	end

endmodule

FILE: design/cri_rsrp_report_unpacker.sv
// Channel | dir | handshake             | beat contents
// in      | in  | in_valid / in_ready   | report_bits, report_length
// out     | out | out_valid / out_ready | entry_index, resource_indicator, beam_rsrp,
//         |     |                       | last, length_mismatch
// cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// A report is registered, decoded in one pass into a result set, and the set
// then leaves one entry per cycle while out_ready is high; a report holds 1 to 4
// entries. A new report is taken every cycle the input register frees.
// Each report passes the input register and then the result set register.
// The output beat sits in the result set register and holds while out_ready is low.
// Reset clears both valid flags and sets both counts to 1. Depends on crru_pkg
// and crru_decode.
module cri_rsrp_report_unpacker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [crru_pkg::MAX_REPORT_BITS-1:0] report_bits,
	input  logic [crru_pkg::LEN_W-1:0]           report_length,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [crru_pkg::IDX_W-1:0]           entry_index,
	output logic [crru_pkg::CRI_W-1:0]           resource_indicator,
	output logic signed [crru_pkg::RSRP_W-1:0]   beam_rsrp,
	output logic                                 last,
	output logic                                 length_mismatch,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [crru_pkg::CFGI_W-1:0]          cfg_index,
	input  logic [crru_pkg::RCNT_W-1:0]          cfg_data
);

	logic [crru_pkg::RCNT_W-1:0] resource_count_q;
	logic [crru_pkg::NREP_W-1:0] reported_count_q;

	logic                                 valid_s1;
	logic [crru_pkg::MAX_REPORT_BITS-1:0] bits_s1;
	logic [crru_pkg::LEN_W-1:0]           length_s1;

	logic                  valid_s2;
	crru_pkg::report_set_t set_s2;
	crru_pkg::report_set_t set_d;
	logic [crru_pkg::IDX_W-1:0] ptr_q;

	logic set_done;
	logic load_s2;
	logic in_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resource_count_q <= 7'd1;
			reported_count_q <= 3'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				crru_pkg::CFG_RESOURCE_COUNT: resource_count_q <= cfg_data;
				crru_pkg::CFG_REPORTED_COUNT: reported_count_q <= cfg_data[crru_pkg::NREP_W-1:0];
				default: ;
			endcase
		end
	end

	crru_decode u_decode (
		.report_bits    (bits_s1),
		.report_length  (length_s1),
		.resource_count (resource_count_q),
		.reported_count (reported_count_q),
		.set            (set_d)
	);

	assign last     = (ptr_q == set_s2.last_idx);
	assign set_done = !valid_s2 || (out_ready && last);
	assign load_s2  = valid_s1 && set_done;
	assign in_ready = !valid_s1 || set_done;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			bits_s1   <= report_bits;
			length_s1 <= report_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			ptr_q    <= '0;
		end else if (set_done) begin
			valid_s2 <= valid_s1;
			ptr_q    <= '0;
		end else if (out_ready) begin
			ptr_q <= ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			set_s2 <= set_d;
		end
	end

	assign out_valid          = valid_s2;
	assign entry_index        = ptr_q;
	assign resource_indicator = set_s2.cri[ptr_q];
	assign beam_rsrp          = $signed(set_s2.rsrp[ptr_q]);
	assign length_mismatch    = set_s2.mismatch;

endmodule

FILE: design/crru_checker.sv
// Port-level checks for the report unpacker and the bind that attaches them.
// Depends on crru_pkg and cri_rsrp_report_unpacker.
module crru_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [crru_pkg::IDX_W-1:0]         entry_index,
	input logic [crru_pkg::CRI_W-1:0]         resource_indicator,
	input logic signed [crru_pkg::RSRP_W-1:0] beam_rsrp,
	input logic                               last,
	input logic                               length_mismatch
);

	// A stalled beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entry_index)
			&& $stable(resource_indicator) && $stable(beam_rsrp) && $stable(last))
		else $error("output beat changed while stalled");

	// Entries of one report follow in order with no gap.
	a_next_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid
			&& entry_index == $past(entry_index) + 2'd1)
		else $error("entry sequence broken inside a report");

	// The mismatch flag is the same on every entry of one report.
	a_mismatch_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> $stable(length_mismatch))
		else $error("length mismatch flag changed inside a report");

	// A new report always opens with its first entry.
	a_first_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid || entry_index == '0)
		else $error("report did not start at entry zero");

endmodule

bind cri_rsrp_report_unpacker crru_checker u_crru_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.entry_index        (entry_index),
	.resource_indicator (resource_indicator),
	.beam_rsrp          (beam_rsrp),
	.last               (last),
	.length_mismatch    (length_mismatch)
);
